[sv/gtg_pkg.sv]
// shared types, constants and the cordic angle table for the go-to-goal controller
package gtg_pkg;

    // width of the loop step index (covers up to 24 iterations)
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    // digit-by-digit square root of a 41-bit value: two bits a step
    localparam int SQRT_STEPS = 21;

    // pi in Q29
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_TOL,
        ST_CHECK,
        ST_LOOP,
        ST_LIN,
        ST_ZH,
        ST_ZL,
        ST_BRG,
        ST_ANG,
        ST_FIN,
        ST_DONE
    } state_t;

    // control from the sequencer to the iteration datapath
    typedef struct packed {
        logic  load;
        logic  step;
        logic  cordic_en;
        step_t idx;
    } iter_ctrl_t;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [29:0] atan_entry(input step_t i);
        logic [29:0] v;
        unique case (i)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

[sv/go_to_goal_p_controller.sv]
// top level of the proportional go-to-goal controller
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: pos_x, pos_y, heading
//  m_      | out       | m_tvalid/m_tready  | m_tdata: lin, ang; m_tuser: arrived
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a pose beat is held from accept back to ready by the shared iteration loop, which
// runs the cordic and the square root side by side; an arrival beat skips the loop and
// goes straight from the arrival test to the output
// a single 16x32 multiplier serves squares, tolerance, gains and the angle scale
// the output register holds a finished beat while the next pose is taken; a
// stalled output only holds the sequencer at its final step
// reset loads the default goal, tolerance and gains and clears the arrived flag
module go_to_goal_p_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [15:0], pos_y [31:16], heading [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // linear_velocity [17:0], angular_velocity [37:18], zero
    output logic        m_tuser,   // arrived [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ITERS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int LOOP_N = (ITERS > gtg_pkg::SQRT_STEPS) ? ITERS : gtg_pkg::SQRT_STEPS;

    localparam logic [2:0] CFG_GOAL_X  = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y  = 3'd1;
    localparam logic [2:0] CFG_TOL     = 3'd2;
    localparam logic [2:0] CFG_LIN_GN  = 3'd3;
    localparam logic [2:0] CFG_ANG_GN  = 3'd4;

    gtg_pkg::state_t     state_reg, state_next;
    gtg_pkg::step_t      k_reg;
    gtg_pkg::iter_ctrl_t ictrl;

    logic [15:0]        goal_x_reg, goal_y_reg, tol_reg, lin_gain_reg, ang_gain_reg;
    logic               goal_reached_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [15:0]        hd_reg;
    logic [32:0]        s_reg;
    logic [15:0]        mul_a;
    logic [31:0]        mul_b;
    logic [47:0]        mul_p_reg;
    logic [63:0]        acc_reg;
    logic signed [18:0] err_reg;
    logic [17:0]        lin_reg;
    logic [19:0]        ang_reg;
    logic               arr_reg;
    logic               m_tvalid_reg;
    logic [17:0]        m_lin_reg;
    logic [19:0]        m_ang_reg;
    logic               m_arr_reg;

    logic [20:0]        dist_w;
    logic signed [33:0] z_w;
    logic [16:0]        dx_mag_w, dy_mag_w;
    logic [33:0]        z_mag_w;
    logic               reached_w;
    logic [37:0]        lin_sum_w;
    logic [17:0]        lin_sat_w;
    logic [63:0]        brg_sum_w;
    logic signed [18:0] brg_w, err_w;
    logic [18:0]        err_abs_w;
    logic [34:0]        ang_sum_w;
    logic [22:0]        ang_q_w;
    logic [19:0]        ang_sat_w;
    logic               out_load_w;

    // iteration datapath
    gtg_iter u_iter (
        .clk  (clk),
        .ctrl (ictrl),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .s    (s_reg),
        .root (dist_w),
        .z    (z_w)
    );

    // magnitudes and arrival test
    assign dx_mag_w  = dx_reg[16] ? 17'(-dx_reg) : dx_reg;
    assign dy_mag_w  = dy_reg[16] ? 17'(-dy_reg) : dy_reg;
    assign z_mag_w   = z_w[33] ? 34'(-z_w) : z_w;
    assign reached_w = goal_reached_reg || (s_reg <= {1'b0, mul_p_reg[31:0]});

    // linear velocity: round and saturate gain * distance
    assign lin_sum_w = {1'b0, mul_p_reg[36:0]} + 38'd32768;
    assign lin_sat_w = (lin_sum_w[37:16] > 22'd262143) ? 18'h3FFFF : lin_sum_w[33:16];

    // bearing from z * pi, then heading error
    assign brg_sum_w = acc_reg + {16'b0, mul_p_reg} + (64'h1 << 46);
    assign brg_w     = z_w[33] ? -$signed({2'b0, brg_sum_w[63:47]})
                               :  $signed({2'b0, brg_sum_w[63:47]});
    assign err_w     = brg_w - {{3{hd_reg[15]}}, hd_reg};
    assign err_abs_w = err_reg[18] ? 19'(-err_reg) : err_reg;

    // angular velocity: round and saturate gain * error
    assign ang_sum_w = {1'b0, mul_p_reg[33:0]} + 35'd2048;
    assign ang_q_w   = ang_sum_w[34:12];

    always_comb
    begin
        if (err_reg[18])
            ang_sat_w = (ang_q_w > 23'd524288) ? 20'h80000 : 20'(20'd0 - ang_q_w[19:0]);
        else
            ang_sat_w = (ang_q_w > 23'd524287) ? 20'h7FFFF : ang_q_w[19:0];
    end

    assign out_load_w = (state_reg == gtg_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtg_pkg::ST_IDLE:   if (s_tvalid) state_next = gtg_pkg::ST_SQ_DX;
            gtg_pkg::ST_SQ_DX:  state_next = gtg_pkg::ST_SQ_DY;
            gtg_pkg::ST_SQ_DY:  state_next = gtg_pkg::ST_SQ_TOL;
            gtg_pkg::ST_SQ_TOL: state_next = gtg_pkg::ST_CHECK;
            gtg_pkg::ST_CHECK:  state_next = reached_w ? gtg_pkg::ST_DONE : gtg_pkg::ST_LOOP;
            gtg_pkg::ST_LOOP:
                if (k_reg == gtg_pkg::step_t'(LOOP_N - 1)) state_next = gtg_pkg::ST_LIN;
            gtg_pkg::ST_LIN:    state_next = gtg_pkg::ST_ZH;
            gtg_pkg::ST_ZH:     state_next = gtg_pkg::ST_ZL;
            gtg_pkg::ST_ZL:     state_next = gtg_pkg::ST_BRG;
            gtg_pkg::ST_BRG:    state_next = gtg_pkg::ST_ANG;
            gtg_pkg::ST_ANG:    state_next = gtg_pkg::ST_FIN;
            gtg_pkg::ST_FIN:    state_next = gtg_pkg::ST_DONE;
            gtg_pkg::ST_DONE:   if (out_load_w) state_next = gtg_pkg::ST_IDLE;
            default:            state_next = gtg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and iteration control
    always_comb
    begin
        s_tready        = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        ictrl.load      = 1'b0;
        ictrl.step      = 1'b0;
        ictrl.cordic_en = (k_reg < gtg_pkg::step_t'(ITERS));
        ictrl.idx       = k_reg;
        unique case (state_reg)
            gtg_pkg::ST_IDLE:   s_tready = 1'b1;
            gtg_pkg::ST_SQ_DX:
            begin
                mul_a = dx_mag_w[15:0];
                mul_b = {16'b0, dx_mag_w[15:0]};
            end
            gtg_pkg::ST_SQ_DY:
            begin
                mul_a = dy_mag_w[15:0];
                mul_b = {16'b0, dy_mag_w[15:0]};
            end
            gtg_pkg::ST_SQ_TOL:
            begin
                mul_a = tol_reg;
                mul_b = {16'b0, tol_reg};
            end
            gtg_pkg::ST_CHECK:  ictrl.load = ~reached_w;
            gtg_pkg::ST_LOOP:   ictrl.step = 1'b1;
            gtg_pkg::ST_LIN:
            begin
                mul_a = lin_gain_reg;
                mul_b = {11'b0, dist_w};
            end
            gtg_pkg::ST_ZH:
            begin
                mul_a = z_mag_w[31:16];
                mul_b = {1'b0, gtg_pkg::PI_Q29};
            end
            gtg_pkg::ST_ZL:
            begin
                mul_a = z_mag_w[15:0];
                mul_b = {1'b0, gtg_pkg::PI_Q29};
            end
            gtg_pkg::ST_ANG:
            begin
                mul_a = ang_gain_reg;
                mul_b = {14'b0, err_abs_w[17:0]};
            end
            default: ;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gtg_pkg::ST_IDLE;
            k_reg            <= '0;
            goal_reached_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            goal_x_reg       <= 16'd2048;
            goal_y_reg       <= 16'd2048;
            tol_reg          <= 16'd20;
            lin_gain_reg     <= 16'd2048;
            ang_gain_reg     <= 16'd16384;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gtg_pkg::ST_CHECK)
                k_reg <= '0;
            else if (state_reg == gtg_pkg::ST_LOOP)
                k_reg <= k_reg + 1'b1;
            if ((state_reg == gtg_pkg::ST_CHECK) && reached_w)
                goal_reached_reg <= 1'b1;
            if (out_load_w)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            // register write beat
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GOAL_X: goal_x_reg   <= cfg_data;
                    CFG_GOAL_Y: goal_y_reg   <= cfg_data;
                    CFG_TOL:    tol_reg      <= cfg_data;
                    CFG_LIN_GN: lin_gain_reg <= cfg_data;
                    CFG_ANG_GN: ang_gain_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mul_p_reg <= 48'(mul_a) * 48'(mul_b);
        unique case (state_reg)
            gtg_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    dx_reg <= {goal_x_reg[15], goal_x_reg} - {s_tdata[15], s_tdata[15:0]};
                    dy_reg <= {goal_y_reg[15], goal_y_reg} - {s_tdata[31], s_tdata[31:16]};
                    hd_reg <= s_tdata[47:32];
                end
            gtg_pkg::ST_SQ_DY:  s_reg <= {1'b0, mul_p_reg[31:0]};
            gtg_pkg::ST_SQ_TOL: s_reg <= s_reg + {1'b0, mul_p_reg[31:0]};
            gtg_pkg::ST_CHECK:
            begin
                arr_reg <= reached_w;
                lin_reg <= '0;
                ang_reg <= '0;
            end
            gtg_pkg::ST_ZH:     lin_reg <= lin_sat_w;
            gtg_pkg::ST_ZL:     acc_reg <= {mul_p_reg, 16'b0};
            gtg_pkg::ST_BRG:    err_reg <= err_w;
            gtg_pkg::ST_FIN:    ang_reg <= ang_sat_w;
            default: ;
        endcase
        // output register
        if (out_load_w)
        begin
            m_lin_reg <= lin_reg;
            m_ang_reg <= ang_reg;
            m_arr_reg <= arr_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b0, m_ang_reg, m_lin_reg};
    assign m_tuser   = m_arr_reg;

`ifndef NO_ASSERTIONS
    // arrival flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        goal_reached_reg |=> goal_reached_reg)
        else $error("arrival flag dropped");

    // an arrived beat carries zero velocities
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 40'd0))
        else $error("arrived beat with nonzero velocity");

    // a pose beat blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accept");
`endif

endmodule

[sv/gtg_iter.sv]
// iteration datapath: cordic vectoring for the bearing and a bit-pair square root
module gtg_iter (
    input  logic                clk,
    input  gtg_pkg::iter_ctrl_t ctrl,
    input  logic signed [16:0]  dx,
    input  logic signed [16:0]  dy,
    input  logic [32:0]         s,
    output logic [20:0]         root,
    output logic signed [33:0]  z
);

    localparam logic signed [33:0] Z_HALF = 34'sh080000000;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic signed [33:0] x0_w, y0_w, xs_w, ys_w, atan_w;
    logic [40:0]        rem_reg, root_reg, sbit_reg;
    logic [40:0]        rem_next, root_next, sbit_next;
    logic [41:0]        trial_w;

    // cordic start vector, scaled by 4096
    assign x0_w   = {{5{dx[16]}}, dx, 12'b0};
    assign y0_w   = {{5{dy[16]}}, dy, 12'b0};
    assign xs_w   = x_reg >>> ctrl.idx;
    assign ys_w   = y_reg >>> ctrl.idx;
    assign atan_w = $signed({4'b0, gtg_pkg::atan_entry(ctrl.idx)});

    // cordic micro-rotation
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctrl.load)
        begin
            if (dx < 0)
            begin
                x_next = -x0_w;
                y_next = -y0_w;
                z_next = (dy >= 0) ? Z_HALF : -Z_HALF;
            end
            else
            begin
                x_next = x0_w;
                y_next = y0_w;
                z_next = '0;
            end
        end
        else if (ctrl.step && ctrl.cordic_en)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys_w;
                y_next = y_reg - xs_w;
                z_next = z_reg + atan_w;
            end
            else
            begin
                x_next = x_reg - ys_w;
                y_next = y_reg + xs_w;
                z_next = z_reg - atan_w;
            end
        end
    end

    // square root step on s * 256
    assign trial_w = {1'b0, root_reg} + {1'b0, sbit_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        sbit_next = sbit_reg;
        if (ctrl.load)
        begin
            rem_next  = {s, 8'b0};
            root_next = '0;
            sbit_next = 41'h1 << 40;
        end
        else if (ctrl.step && (sbit_reg != '0))
        begin
            if ({1'b0, rem_reg} >= trial_w)
            begin
                rem_next  = rem_reg - trial_w[40:0];
                root_next = (root_reg >> 1) + sbit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            sbit_next = sbit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sbit_reg <= sbit_next;
    end

    assign root = root_reg[20:0];
    assign z    = z_reg;

endmodule
